>>> sv/crlt_pkg.sv
// Shared types, constants and controller/datapath interface structs for the range lock table.
package crlt_pkg;

  localparam int NUM_CHUNKS_DEF     = 1024;
  localparam int REQUESTER_BITS_DEF = 8;
  localparam int COUNT_BITS_DEF     = 8;

  localparam int REQ_PORT_W  = 8;
  localparam int RANGE_W     = 40;
  localparam int DIV_W       = 41;
  localparam int CHUNK_MIN   = 16;
  localparam int STATUS_W    = 2;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_BUSY = 2'd1,
    ST_ERR  = 2'd2
  } status_t;

  typedef enum logic {
    ACT_LOCK   = 1'b0,
    ACT_UNLOCK = 1'b1
  } action_t;

  typedef struct packed {
    logic load;
    logic walk_start;
    logic step;
    logic update_mode;
    logic clear_step;
  } dp_cmd_t;

  typedef struct packed {
    logic    len_zero;
    logic    div_done;
    logic    range_err;
    logic    issued_all;
    logic    walk_done;
    logic    clear_done;
    status_t chk_status;
  } dp_sts_t;

endpackage

>>> sv/crlt_div.sv
// Restoring radix-2 divider that produces one quotient bit per cycle.
module crlt_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [crlt_pkg::DIV_W-1:0] dividend,
  input  logic [crlt_pkg::DIV_W-1:0] divisor,
  output logic                       busy,
  output logic [crlt_pkg::DIV_W-1:0] quotient
);
  import crlt_pkg::*;

  localparam int CNT_W = $clog2(DIV_W);

  logic             busy_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DIV_W-1:0] rem_r;
  logic [DIV_W-1:0] quo_r;
  logic [DIV_W-1:0] dvs_r;
  logic [DIV_W:0]   rem_sh;
  logic [DIV_W:0]   dvs_ext;
  logic [DIV_W:0]   diff;
  logic             ge;
  logic [DIV_W-1:0] rem_nxt;

  always_comb begin
    rem_sh  = {rem_r, quo_r[DIV_W-1]};
    dvs_ext = {1'b0, dvs_r};
    diff    = rem_sh - dvs_ext;
    ge      = (rem_sh >= dvs_ext);
    rem_nxt = ge ? diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(DIV_W - 1);
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[DIV_W-2:0], ge};
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

>>> sv/crlt_dp.sv
// Datapath: request registers, chunk index dividers, hold table memories and range walker.
module crlt_dp #(
  parameter int NUM_CHUNKS     = crlt_pkg::NUM_CHUNKS_DEF,
  parameter int REQUESTER_BITS = crlt_pkg::REQUESTER_BITS_DEF,
  parameter int COUNT_BITS     = crlt_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  crlt_pkg::dp_cmd_t               cmd,
  output crlt_pkg::dp_sts_t               sts,
  input  logic                            cfg_we,
  input  logic [crlt_pkg::DIV_W-1:0]      cfg_data,
  input  logic                            in_action,
  input  logic [crlt_pkg::REQ_PORT_W-1:0] in_requester,
  input  logic [crlt_pkg::RANGE_W-1:0]    in_range_start,
  input  logic [crlt_pkg::RANGE_W-1:0]    in_range_length
);
  import crlt_pkg::*;

  localparam int IDX_W = $clog2(NUM_CHUNKS);
  localparam int EXT_W = (REQUESTER_BITS > REQ_PORT_W) ? REQUESTER_BITS : REQ_PORT_W;

  logic [DIV_W-1:0]          chunk_r;
  action_t                   action_r;
  logic [REQUESTER_BITS-1:0] who_r;
  logic                      len_zero_r;
  logic [EXT_W-1:0]          req_ext;
  logic [DIV_W-1:0]          end_byte;
  logic [DIV_W-1:0]          first_q;
  logic [DIV_W-1:0]          last_q;
  logic                      busy_first;
  logic                      busy_last;

  logic [IDX_W-1:0]          addr_r;
  logic [IDX_W-1:0]          last_r;
  logic [IDX_W-1:0]          pend_addr_r;
  logic                      issued_r;
  logic                      pend_r;
  logic                      pend_last_r;
  logic [IDX_W-1:0]          clr_addr_r;
  logic [COUNT_BITS-1:0]     rd_cnt_r;
  logic [REQUESTER_BITS-1:0] rd_hold_r;
  logic                      busy_hit_r;
  logic                      ovf_hit_r;
  logic                      bad_hit_r;
  status_t                   chk_status;
  logic [COUNT_BITS-1:0]     cnt_upd;

  logic [COUNT_BITS-1:0]     cnt_mem  [NUM_CHUNKS];
  logic [REQUESTER_BITS-1:0] hold_mem [NUM_CHUNKS];

  assign req_ext  = EXT_W'(in_requester);
  assign end_byte = DIV_W'(in_range_start) + DIV_W'(in_range_length) - DIV_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_r <= DIV_W'(CHUNK_MIN);
    end else if (cfg_we) begin
      chunk_r <= (cfg_data < DIV_W'(CHUNK_MIN)) ? DIV_W'(CHUNK_MIN) : cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action_r   <= action_t'(in_action);
      who_r      <= req_ext[REQUESTER_BITS-1:0];
      len_zero_r <= (in_range_length == '0);
    end
  end

  crlt_div u_div_first (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.load),
    .dividend (DIV_W'(in_range_start)),
    .divisor  (chunk_r),
    .busy     (busy_first),
    .quotient (first_q)
  );

  crlt_div u_div_last (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.load),
    .dividend (end_byte),
    .divisor  (chunk_r),
    .busy     (busy_last),
    .quotient (last_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issued_r    <= 1'b0;
      pend_r      <= 1'b0;
      pend_last_r <= 1'b0;
      clr_addr_r  <= '0;
    end else begin
      pend_r      <= cmd.step;
      pend_last_r <= cmd.step && (addr_r == last_r);
      if (cmd.clear_step) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
      if (cmd.walk_start) begin
        issued_r <= 1'b0;
      end else if (cmd.step && (addr_r == last_r)) begin
        issued_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_start) begin
      addr_r <= first_q[IDX_W-1:0];
      last_r <= last_q[IDX_W-1:0];
    end else if (cmd.step) begin
      addr_r <= addr_r + 1'b1;
    end
    if (cmd.step) begin
      pend_addr_r <= addr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      rd_cnt_r  <= cnt_mem[addr_r];
      rd_hold_r <= hold_mem[addr_r];
    end
  end

  assign cnt_upd = (action_r == ACT_LOCK) ? rd_cnt_r + 1'b1 : rd_cnt_r - 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.clear_step) begin
      cnt_mem[clr_addr_r] <= '0;
    end else if (pend_r && cmd.update_mode) begin
      cnt_mem[pend_addr_r] <= cnt_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_r && cmd.update_mode && (action_r == ACT_LOCK)) begin
      hold_mem[pend_addr_r] <= who_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_start) begin
      busy_hit_r <= 1'b0;
      ovf_hit_r  <= 1'b0;
      bad_hit_r  <= 1'b0;
    end else if (pend_r && !cmd.update_mode) begin
      if ((rd_cnt_r != '0) && (rd_hold_r != who_r)) begin
        busy_hit_r <= 1'b1;
      end
      if (&rd_cnt_r) begin
        ovf_hit_r <= 1'b1;
      end
      if ((rd_cnt_r == '0) || (rd_hold_r != who_r)) begin
        bad_hit_r <= 1'b1;
      end
    end
  end

  always_comb begin
    chk_status = ST_OK;
    if (action_r == ACT_LOCK) begin
      if (busy_hit_r) begin
        chk_status = ST_BUSY;
      end else if (ovf_hit_r) begin
        chk_status = ST_ERR;
      end
    end else if (bad_hit_r) begin
      chk_status = ST_ERR;
    end
  end

  always_comb begin
    sts.len_zero   = len_zero_r;
    sts.div_done   = !busy_first && !busy_last;
    sts.range_err  = (last_q >= DIV_W'(NUM_CHUNKS));
    sts.issued_all = issued_r;
    sts.walk_done  = pend_r && pend_last_r;
    sts.clear_done = (clr_addr_r == IDX_W'(NUM_CHUNKS - 1));
    sts.chk_status = chk_status;
  end

endmodule

>>> sv/crlt_ctrl.sv
// Controller state machine that sequences clearing, division, check and update passes.
module crlt_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [crlt_pkg::STATUS_W-1:0]  out_status,
  output crlt_pkg::dp_cmd_t              cmd,
  input  crlt_pkg::dp_sts_t              sts
);
  import crlt_pkg::*;

  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_DIV    = 7'b0000100,
    S_CHECK  = 7'b0001000,
    S_EVAL   = 7'b0010000,
    S_UPDATE = 7'b0100000,
    S_FIN    = 7'b1000000
  } state_t;

  state_t  state_r;
  state_t  state_nxt;
  status_t res_r;
  status_t res_nxt;
  logic    out_valid_r;
  status_t out_status_r;
  logic    out_free;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    res_nxt   = res_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        priority if (sts.len_zero) begin
          res_nxt   = ST_OK;
          state_nxt = S_FIN;
        end else if (sts.div_done && sts.range_err) begin
          res_nxt   = ST_ERR;
          state_nxt = S_FIN;
        end else if (sts.div_done) begin
          cmd.walk_start = 1'b1;
          state_nxt      = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.step = !sts.issued_all;
        if (sts.walk_done) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (sts.chk_status != ST_OK) begin
          res_nxt   = sts.chk_status;
          state_nxt = S_FIN;
        end else begin
          cmd.walk_start = 1'b1;
          state_nxt      = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.update_mode = 1'b1;
        cmd.step        = !sts.issued_all;
        if (sts.walk_done) begin
          res_nxt   = ST_OK;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == S_FIN) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if ((state_r == S_FIN) && out_free) begin
      out_status_r <= res_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;

endmodule

>>> sv/chunked_range_lock_table.sv
// Top level of the chunked byte-range lock table.
// Sequence to out_valid: a grant or unlock runs division, a check pass over the table, an
// evaluate step and an update pass before the result is issued; a check pass that finds a
// conflict or error skips the update pass, an out-of-table range ends after division, and a
// zero length goes straight to the result. Transactions are taken one at a time.
// Reset clears control state and then sweeps the hold count table.
module chunked_range_lock_table #(
  parameter int NUM_CHUNKS     = crlt_pkg::NUM_CHUNKS_DEF,
  parameter int REQUESTER_BITS = crlt_pkg::REQUESTER_BITS_DEF,
  parameter int COUNT_BITS     = crlt_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [crlt_pkg::DIV_W-1:0]      cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_action,
  input  logic [crlt_pkg::REQ_PORT_W-1:0] in_requester,
  input  logic [crlt_pkg::RANGE_W-1:0]    in_range_start,
  input  logic [crlt_pkg::RANGE_W-1:0]    in_range_length,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [crlt_pkg::STATUS_W-1:0]   out_status
);
  import crlt_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready = 1'b1;

  crlt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_status (out_status),
    .cmd        (cmd),
    .sts        (sts)
  );

  crlt_dp #(
    .NUM_CHUNKS     (NUM_CHUNKS),
    .REQUESTER_BITS (REQUESTER_BITS),
    .COUNT_BITS     (COUNT_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_data        (cfg_data),
    .in_action       (in_action),
    .in_requester    (in_requester),
    .in_range_start  (in_range_start),
    .in_range_length (in_range_length)
  );

  // A new transaction is never taken on the cycle after one was accepted.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted on consecutive cycles");

  // Table walks never overlap the clearing sweep or a request load.
  a_step_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> (!cmd.clear_step && !cmd.load && !cmd.walk_start))
    else $error("walk step overlaps clear or load");

  // Once the last chunk of a walk has been evaluated, no further read is issued.
  a_walk_stops: assert property (@(posedge clk) disable iff (!rst_n)
    sts.walk_done |-> !cmd.step)
    else $error("read issued after walk completed");

  // A delivered result carries one of the defined status codes.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_BUSY || out_status == ST_ERR))
    else $error("undefined status code on output");

endmodule

>>> dv/chunked_range_lock_table_tb.sv
// Self-checking testbench for chunked_range_lock_table: directed rows, random lock traffic.
module chunked_range_lock_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import crlt_pkg::*;

  localparam int NCHUNK = NUM_CHUNKS_DEF;
  localparam int COUNT_TOP = (1 << COUNT_BITS_DEF) - 1;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam longint unsigned FIELD_MAX = (64'd1 << RANGE_W) - 1;
  localparam logic [RANGE_W-1:0] FMAX = '1;

  typedef struct {
    bit                   is_cfg;
    logic [DIV_W-1:0]     cfg_value;
    action_t              act;
    logic [REQ_PORT_W-1:0] who;
    logic [RANGE_W-1:0]   first_byte;
    logic [RANGE_W-1:0]   nbytes;
    bit                   typed;
    status_t              want;
  } step_row_t;

  typedef struct {
    logic [REQ_PORT_W-1:0] who;
    logic [RANGE_W-1:0]    first_byte;
    logic [RANGE_W-1:0]    nbytes;
  } grant_t;

  typedef struct {
    status_t     st;
    int unsigned tag;
  } status_entry_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [DIV_W-1:0]       cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic                   in_action = 1'b0;
  logic [REQ_PORT_W-1:0]  in_requester = '0;
  logic [RANGE_W-1:0]     in_range_start = '0;
  logic [RANGE_W-1:0]     in_range_length = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [STATUS_W-1:0]    out_status;

  logic [COUNT_BITS_DEF-1:0]     hold_cnt [NCHUNK];
  logic [REQUESTER_BITS_DEF-1:0] owner [NCHUNK];
  longint unsigned chunk_bytes = CHUNK_MIN;

  status_entry_t status_due [$];
  status_entry_t head;
  grant_t        granted [$];
  int unsigned   n_sent = 0;
  int unsigned   mismatches = 0;
  int unsigned   quiet_cycles = 0;
  int unsigned   gap_pct = 25;
  bit            idle_ok = 1'b1;

  step_row_t dir_rows [30] = '{
    '{1'b0, 41'd0, ACT_LOCK,   8'h00, 40'd0,     40'd0,     1'b1, ST_OK},
    '{1'b0, 41'd0, ACT_UNLOCK, 8'hFF, FMAX,      40'd0,     1'b1, ST_OK},
    '{1'b0, 41'd0, ACT_LOCK,   8'h12, 40'd0,     40'd16,    1'b1, ST_OK},
    '{1'b0, 41'd0, ACT_LOCK,   8'h34, 40'd15,    40'd1,     1'b1, ST_BUSY},
    '{1'b0, 41'd0, ACT_UNLOCK, 8'h34, 40'd0,     40'd1,     1'b1, ST_ERR},
    '{1'b0, 41'd0, ACT_LOCK,   8'h12, 40'd0,     40'd32,    1'b0, ST_OK},
    '{1'b0, 41'd0, ACT_UNLOCK, 8'h12, 40'd16,    40'd16,    1'b0, ST_OK},
    '{1'b0, 41'd0, ACT_UNLOCK, 8'h12, 40'd16,    40'd1,     1'b1, ST_ERR},
    '{1'b0, 41'd0, ACT_LOCK,   8'hAB, 40'd16368, 40'd16,    1'b0, ST_OK},
    '{1'b0, 41'd0, ACT_LOCK,   8'hAB, 40'd16368, 40'd17,    1'b1, ST_ERR},
    '{1'b0, 41'd0, ACT_LOCK,   8'h5A, FMAX,      FMAX,      1'b1, ST_ERR},
    '{1'b0, 41'd0, ACT_UNLOCK, 8'hA5, FMAX,      FMAX,      1'b1, ST_ERR},
    '{1'b0, 41'd0, ACT_UNLOCK, 8'hAB, 40'd16368, 40'd16,    1'b0, ST_OK},
    '{1'b0, 41'd0, ACT_LOCK,   8'h5A, 40'd0,     40'd16384, 1'b0, ST_OK},
    '{1'b0, 41'd0, ACT_UNLOCK, 8'h12, 40'd0,     40'd16,    1'b0, ST_OK},
    '{1'b0, 41'd0, ACT_UNLOCK, 8'h12, 40'd5,     40'd3,     1'b0, ST_OK},
    '{1'b0, 41'd0, ACT_LOCK,   8'h5A, 40'd0,     40'd16384, 1'b0, ST_OK},
    '{1'b0, 41'd0, ACT_UNLOCK, 8'h5A, 40'd0,     40'd16384, 1'b0, ST_OK},
    '{1'b1, 41'd0, ACT_LOCK,   8'h00, 40'd0,     40'd0,     1'b0, ST_OK},
    '{1'b0, 41'd0, ACT_LOCK,   8'h77, 40'd16368, 40'd17,    1'b1, ST_ERR},
    '{1'b1, 41'h1FF_FFFF_FFFF, ACT_LOCK, 8'h00, 40'd0, 40'd0, 1'b0, ST_OK},
    '{1'b0, 41'd0, ACT_LOCK,   8'hFF, FMAX,      FMAX,      1'b0, ST_OK},
    '{1'b0, 41'd0, ACT_UNLOCK, 8'hFF, FMAX,      FMAX,      1'b0, ST_OK},
    '{1'b1, 41'h100_0000_0000, ACT_LOCK, 8'h00, 40'd0, 40'd0, 1'b0, ST_OK},
    '{1'b0, 41'd0, ACT_LOCK,   8'h00, FMAX,      40'd2,     1'b0, ST_OK},
    '{1'b0, 41'd0, ACT_UNLOCK, 8'h00, FMAX,      40'd2,     1'b0, ST_OK},
    '{1'b1, 41'd17, ACT_LOCK,  8'h00, 40'd0,     40'd0,     1'b0, ST_OK},
    '{1'b0, 41'd0, ACT_LOCK,   8'h3C, 40'd17408, 40'd1,     1'b1, ST_ERR},
    '{1'b0, 41'd0, ACT_LOCK,   8'h3C, 40'd17407, 40'd1,     1'b0, ST_OK},
    '{1'b0, 41'd0, ACT_UNLOCK, 8'h3C, 40'd17391, 40'd17,    1'b0, ST_OK}
  };

  chunked_range_lock_table dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_requester   (in_requester),
    .in_range_start (in_range_start),
    .in_range_length(in_range_length),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic longint unsigned rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic status_t apply_request(action_t act, logic [REQ_PORT_W-1:0] who,
                                            logic [RANGE_W-1:0] st, logic [RANGE_W-1:0] ln);
    longint unsigned s;
    longint unsigned n;
    longint unsigned lo;
    longint unsigned hi;
    if (ln == '0) return ST_OK;
    s = 64'(st);
    n = 64'(ln);
    lo = s / chunk_bytes;
    hi = (s + n - 1) / chunk_bytes;
    if (hi >= NCHUNK) return ST_ERR;
    if (act == ACT_LOCK) begin
      for (longint unsigned i = lo; i <= hi; i++)
        if (hold_cnt[i] != 0 && owner[i] != who) return ST_BUSY;
      for (longint unsigned i = lo; i <= hi; i++)
        if (hold_cnt[i] == COUNT_TOP) return ST_ERR;
      for (longint unsigned i = lo; i <= hi; i++) begin
        hold_cnt[i] = hold_cnt[i] + 1'b1;
        owner[i] = who;
      end
    end else begin
      for (longint unsigned i = lo; i <= hi; i++)
        if (hold_cnt[i] == 0 || owner[i] != who) return ST_ERR;
      for (longint unsigned i = lo; i <= hi; i++)
        hold_cnt[i] = hold_cnt[i] - 1'b1;
    end
    return ST_OK;
  endfunction

  function automatic void make_range(int unsigned nchunks, output logic [RANGE_W-1:0] st,
                                     output logic [RANGE_W-1:0] ln);
    longint unsigned maxf;
    longint unsigned f;
    longint unsigned top;
    longint unsigned s;
    longint unsigned e;
    maxf = FIELD_MAX / chunk_bytes;
    if (maxf > NCHUNK - 1) maxf = NCHUNK - 1;
    f = 64'($urandom_range(0, int'(maxf)));
    top = f + nchunks - 1;
    if (top > NCHUNK - 1) top = NCHUNK - 1;
    s = f * chunk_bytes + rand64() % chunk_bytes;
    if (s > FIELD_MAX) s = FIELD_MAX;
    e = top * chunk_bytes + rand64() % chunk_bytes;
    if (e < s) e = s;
    if (e > s + FIELD_MAX - 1) e = s + FIELD_MAX - 1;
    st = s[RANGE_W-1:0];
    ln = 40'(e - s + 1);
  endfunction

  task automatic send_request(action_t act, logic [REQ_PORT_W-1:0] who,
                              logic [RANGE_W-1:0] st, logic [RANGE_W-1:0] ln,
                              bit typed, status_t want);
    status_t got;
    status_entry_t ent;
    grant_t g;
    if (idle_ok && $urandom_range(1, 100) <= gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_action       <= act;
    in_requester    <= who;
    in_range_start  <= st;
    in_range_length <= ln;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    got = apply_request(act, who, st, ln);
    ent.st = typed ? want : got;
    ent.tag = n_sent;
    status_due.push_back(ent);
    n_sent++;
    if (act == ACT_LOCK && got == ST_OK) begin
      g.who = who;
      g.first_byte = st;
      g.nbytes = ln;
      granted.push_back(g);
    end
  endtask

  // The table is reprogrammed only once every outstanding status has returned.
  task automatic write_chunk_size(logic [DIV_W-1:0] v);
    in_valid <= 1'b0;
    do @(posedge clk); while (status_due.size() != 0);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    chunk_bytes = (v < DIV_W'(CHUNK_MIN)) ? 64'(CHUNK_MIN) : 64'(v);
  endtask

  task automatic run_phase(logic [DIV_W-1:0] cfg_word, int unsigned n_items);
    logic [REQ_PORT_W-1:0] pool [4];
    logic [RANGE_W-1:0]    st;
    logic [RANGE_W-1:0]    ln;
    grant_t                g;
    int unsigned           pick;
    int unsigned           k;
    write_chunk_size(cfg_word);
    gap_pct = 25 * $urandom_range(0, 2);
    foreach (pool[i]) pool[i] = 8'($urandom_range(0, 255));
    repeat (n_items) begin
      pick = $urandom_range(0, 99);
      if (granted.size() == 0 && pick >= 35 && pick < 90) pick = 0;
      if (pick < 35) begin
        make_range(($urandom_range(0, 19) == 0) ? $urandom_range(5, 48) : $urandom_range(1, 3),
                   st, ln);
        send_request(ACT_LOCK, pool[$urandom_range(0, 3)], st, ln, 1'b0, ST_OK);
      end else if (pick < 62) begin
        k = $urandom_range(0, granted.size() - 1);
        g = granted[k];
        granted.delete(k);
        send_request(ACT_UNLOCK, g.who, g.first_byte, g.nbytes, 1'b0, ST_OK);
      end else if (pick < 76) begin
        g = granted[$urandom_range(0, granted.size() - 1)];
        if ($urandom_range(0, 1) == 0 && longint'(g.nbytes) + chunk_bytes <= FIELD_MAX)
          send_request(ACT_UNLOCK, g.who, g.first_byte, 40'(g.nbytes + chunk_bytes), 1'b0,
                       ST_OK);
        else
          send_request(ACT_UNLOCK, g.who ^ 8'($urandom_range(1, 255)), g.first_byte, g.nbytes,
                       1'b0, ST_OK);
      end else if (pick < 90) begin
        g = granted[$urandom_range(0, granted.size() - 1)];
        ln = $urandom_range(0, 1) ? g.nbytes : 40'd1;
        send_request(ACT_LOCK, g.who ^ 8'($urandom_range(1, 255)), g.first_byte, ln, 1'b0,
                     ST_OK);
      end else begin
        st = $urandom_range(0, 1) ? 40'(rand64()) : 40'($urandom_range(0, 20000));
        case ($urandom_range(0, 3))
          0: ln = '0;
          1: ln = 40'(rand64());
          2: ln = 40'($urandom_range(1, 64));
          default: ln = 40'($urandom_range(1, 5000));
        endcase
        send_request(action_t'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), st, ln,
                     1'b0, ST_OK);
      end
    end
    while (granted.size() != 0) begin
      g = granted.pop_front();
      send_request(ACT_UNLOCK, g.who, g.first_byte, g.nbytes, 1'b0, ST_OK);
    end
  endtask

  // One requester drives a single chunk to its maximum hold count and past it.
  task automatic saturate_chunk();
    logic [REQ_PORT_W-1:0] who;
    longint unsigned       base;
    int unsigned           off;
    write_chunk_size(41'd64);
    idle_ok = 1'b0;
    granted.delete();
    who = 8'($urandom_range(0, 255));
    base = 64 * longint'($urandom_range(1, NCHUNK - 2));
    repeat (COUNT_TOP + 1) begin
      off = $urandom_range(0, 63);
      send_request(ACT_LOCK, who, 40'(base + off), 40'($urandom_range(1, 64 - off)), 1'b0,
                   ST_OK);
    end
    send_request(ACT_LOCK, who ^ 8'h01, 40'(base), 40'd64, 1'b0, ST_OK);
    send_request(ACT_LOCK, who, 40'(base - 64), 40'd65, 1'b0, ST_OK);
    send_request(ACT_UNLOCK, who, 40'(base), 40'd1, 1'b0, ST_OK);
    send_request(ACT_LOCK, who, 40'(base + 63), 40'd1, 1'b0, ST_OK);
    send_request(ACT_LOCK, who, 40'(base), 40'd64, 1'b0, ST_OK);
  endtask

  initial begin
    @(posedge clk);
    forever begin
      if (idle_ok && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 9) == 0) repeat ($urandom_range(20, 80)) @(posedge clk);
        else repeat ($urandom_range(1, 9)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (status_due.size() == 0) begin
        $display("%0t: status %0d returned with no request outstanding", $time, out_status);
        mismatches++;
      end else begin
        head = status_due.pop_front();
        if (status_t'(out_status) !== head.st) begin
          $display("%0t: request %0d status expected %0d actual %0d", $time, head.tag,
                   head.st, out_status);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired with %0d statuses outstanding", $time,
               status_due.size());
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    foreach (hold_cnt[i]) begin
      hold_cnt[i] = '0;
      owner[i] = '0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    foreach (dir_rows[r]) begin
      if (dir_rows[r].is_cfg)
        write_chunk_size(dir_rows[r].cfg_value);
      else
        send_request(dir_rows[r].act, dir_rows[r].who, dir_rows[r].first_byte,
                     dir_rows[r].nbytes, dir_rows[r].typed, dir_rows[r].want);
    end
    run_phase(41'd16, 30);
    run_phase(41'($urandom_range(17, 700)), 30);
    run_phase(41'd3, 25);
    run_phase(41'((64'd1 << 24) + $urandom_range(0, 9999)), 30);
    run_phase(41'h100_0000_0000, 25);
    run_phase({9'($urandom_range(0, 511)), $urandom}, 25);
    saturate_chunk();
    in_valid <= 1'b0;
    while (status_due.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
